>>> design/ntde_pkg.sv
// Package for the nixie time/date word encoder.
// Holds the item and config types, register indexes and digit helpers.
// No dependencies.
`default_nettype none

package ntde_pkg;

  localparam logic [3:0] BlankCode = 4'hC;
  localparam logic [7:0] TopByte   = 8'hCC;
  localparam logic [5:0] WinFirst  = 6'd45;
  localparam logic [5:0] WinLast   = 6'd52;
  localparam logic [4:0] Noon      = 5'd12;

  typedef enum logic [2:0] {
    CFG_TWELVE_HOUR  = 3'd0,
    CFG_LEADING_ZERO = 3'd1,
    CFG_DATE_FORMAT  = 3'd2,
    CFG_ALT_INTERVAL = 3'd3,
    CFG_ALT_INVERT   = 3'd4,
    CFG_TIME_MODE    = 3'd5,
    CFG_INDICATOR    = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    IND_NONE    = 3'd0,
    IND_STEADY  = 3'd1,
    IND_BLINK   = 3'd2,
    IND_PM      = 3'd3,
    IND_ALT_LO  = 3'd4,
    IND_ALT_HI  = 3'd5
  } ind_mode_e;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [2:0] weekday;
    logic [4:0] day_of_month;
    logic [3:0] month;
  } in_t;

  typedef struct packed {
    logic [31:0] display_word;
    logic [2:0]  colons;
    logic        showing_time;
  } out_t;

  typedef struct packed {
    logic       twelve_hour;
    logic       leading_zero;
    logic       date_format;
    logic [7:0] alternate_interval;
    logic       alternate_invert;
    logic       time_mode;
    logic [2:0] indicator_mode;
  } cfg_t;

  // Tens digit for 0..63 by reciprocal multiply (13/128 ~ 1/10).
  function automatic logic [3:0] div10(input logic [5:0] v);
    logic [9:0] p;
    p = 10'(v) * 10'd13;
    return {1'b0, p[9:7]};
  endfunction

  // Swapped-nibble BCD byte: units in the high nibble, tens in the low.
  function automatic logic [7:0] swap_bcd(input logic [5:0] v);
    logic [3:0] t;
    logic [5:0] u;
    t = div10(v);
    u = v - (6'(t) * 6'd10);
    return {u[3:0], t};
  endfunction

endpackage

`default_nettype wire

>>> design/ntde_word.sv
// Final encode stage logic of the nixie time/date word encoder.
// Builds the display word, colon code and time flag. Depends on ntde_pkg.
`default_nettype none

module ntde_word import ntde_pkg::*; (
  input  in_t        item_i,
  input  logic [7:0] rem_i,
  input  cfg_t       cfg_i,
  output out_t       res_o
);

  logic       win;
  logic       show_time;
  logic       pm;
  logic [4:0] h12;
  logic [7:0] hour_b;
  logic [7:0] min_b;
  logic [7:0] day_b;
  logic [7:0] mon_b;
  logic [7:0] b0;
  logic [7:0] b1;
  logic [3:0] ampm;
  logic [3:0] code_lo;
  logic [3:0] code_hi;
  logic [2:0] colons;

  always_comb begin
    win = (cfg_i.alternate_interval != 8'd0) && (rem_i == 8'd0) &&
          (item_i.second >= WinFirst) && (item_i.second <= WinLast);
    show_time = cfg_i.time_mode ^ (win ^ cfg_i.alternate_invert);
    pm = (item_i.hour >= Noon);

    h12 = item_i.hour;
    if (cfg_i.twelve_hour) begin
      if (item_i.hour > Noon) begin
        h12 = item_i.hour - Noon;
      end else if (item_i.hour == 5'd0) begin
        h12 = Noon;
      end
    end
    hour_b = swap_bcd({1'b0, h12});
    if ((h12 < 5'd10) && !cfg_i.leading_zero) begin
      hour_b[3:0] = BlankCode;
    end

    min_b = swap_bcd(item_i.minute);
    day_b = swap_bcd({1'b0, item_i.day_of_month});
    mon_b = swap_bcd({2'b00, item_i.month});

    if (show_time) begin
      b0 = hour_b;
      b1 = min_b;
    end else begin
      b0 = cfg_i.date_format ? mon_b : day_b;
      b1 = cfg_i.date_format ? day_b : mon_b;
    end

    ampm = (cfg_i.twelve_hour && show_time) ? {3'b000, pm} : BlankCode;
    unique case (item_i.weekday)
      3'd0:    code_lo = (ampm == BlankCode) ? 4'd8 : ampm + 4'd10;
      3'd1:    code_lo = (ampm == BlankCode) ? 4'd9 : ampm + 4'd13;
      default: code_lo = ampm;
    endcase
    code_hi = (item_i.weekday >= 3'd2) ? {1'b0, item_i.weekday - 3'd2} : BlankCode;

    unique case (ind_mode_e'(cfg_i.indicator_mode))
      IND_STEADY: colons = 3'd1;
      IND_BLINK:  colons = {2'b00, item_i.second[0]};
      IND_PM:     colons = {2'b00, pm};
      IND_ALT_LO: colons = item_i.second[0] ? 3'd2 : 3'd3;
      IND_ALT_HI: colons = item_i.second[0] ? 3'd4 : 3'd5;
      default:    colons = 3'd0;
    endcase

    res_o.display_word = {TopByte, code_hi, code_lo, b1, b0};
    res_o.colons       = show_time ? colons : 3'd0;
    res_o.showing_time = show_time;
  end

endmodule

`default_nettype wire

>>> design/nixie_time_date_word_encoder.sv
// Nixie time/date word encoder: four register stages, one item per cycle
// while the output is not stalled. An accepted item passes through the 3
// remainder stages and then the output register. Throughput is set by the
// 2-bit-per-stage minute remainder pipeline; bubbles collapse under stall.
// Reset: asynchronous active low; clears valid bits and loads register
// defaults (time_mode = 1, all others 0). Depends on ntde_pkg, ntde_word.
`default_nettype none

module nixie_time_date_word_encoder import ntde_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_t       out_data_o,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [7:0] cfg_wdata_i
);

  // One restoring-remainder step: shift in the next minute bit, subtract
  // the interval when it fits. For a nonzero interval the partial remainder stays below it.
  function automatic logic [7:0] rem_step(input logic [7:0] rem,
                                          input logic       nbit,
                                          input logic [7:0] div);
    logic [8:0] t;
    logic [8:0] diff;
    t    = {rem, nbit};
    diff = t - {1'b0, div};
    return (t >= {1'b0, div}) ? diff[7:0] : t[7:0];
  endfunction

  // Configuration registers.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{twelve_hour: 1'b0, leading_zero: 1'b0, date_format: 1'b0,
                 alternate_interval: 8'd0, alternate_invert: 1'b0,
                 time_mode: 1'b1, indicator_mode: 3'd0};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TWELVE_HOUR:  cfg_q.twelve_hour        <= cfg_wdata_i[0];
        CFG_LEADING_ZERO: cfg_q.leading_zero       <= cfg_wdata_i[0];
        CFG_DATE_FORMAT:  cfg_q.date_format        <= cfg_wdata_i[0];
        CFG_ALT_INTERVAL: cfg_q.alternate_interval <= cfg_wdata_i;
        CFG_ALT_INVERT:   cfg_q.alternate_invert   <= cfg_wdata_i[0];
        CFG_TIME_MODE:    cfg_q.time_mode          <= cfg_wdata_i[0];
        CFG_INDICATOR:    cfg_q.indicator_mode     <= cfg_wdata_i[2:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // Pipeline: stages 1..3 carry the item and the partial minute remainder
  // (two bits per stage, MSB first); stage 4 is the output register.
  logic       v1_q, v2_q, v3_q, out_v_q;
  in_t        d1_q, d2_q, d3_q;
  logic [7:0] r1_q, r2_q, r3_q;
  logic [7:0] r1_d, r2_d, r3_d;
  out_t       res_d, out_q;
  logic       en1, en2, en3, en4;

  // A stage advances when it is empty or its successor advances.
  assign en4 = !out_v_q || !out_stall_i;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_stall_o = !en1;

  always_comb begin
    r1_d = rem_step(8'd0, in_data_i.minute[5], cfg_q.alternate_interval);
    r1_d = rem_step(r1_d, in_data_i.minute[4], cfg_q.alternate_interval);
    r2_d = rem_step(r1_q, d1_q.minute[3], cfg_q.alternate_interval);
    r2_d = rem_step(r2_d, d1_q.minute[2], cfg_q.alternate_interval);
    r3_d = rem_step(r2_q, d2_q.minute[1], cfg_q.alternate_interval);
    r3_d = rem_step(r3_d, d2_q.minute[0], cfg_q.alternate_interval);
  end

  // Final encode from the stage-3 item and the full remainder.
  ntde_word u_word (
    .item_i (d3_q),
    .rem_i  (r3_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) v1_q    <= in_valid_i;
      if (en2) v2_q    <= v1_q;
      if (en3) v3_q    <= v2_q;
      if (en4) out_v_q <= v3_q;
    end
  end

  // Payload registers: load only when the stage advances, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      d1_q <= in_data_i;
      r1_q <= r1_d;
    end
    if (en2) begin
      d2_q <= d1_q;
      r2_q <= r2_d;
    end
    if (en3) begin
      d3_q <= d2_q;
      r3_q <= r3_d;
    end
    if (en4) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Assertions.
  a_top_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.display_word[31:24] == TopByte))
    else $error("top byte of display word is not blank pair");

  a_date_no_colons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.showing_time) |-> (out_q.colons == 3'd0))
    else $error("colons set while date shown");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && out_v_q))
    else $error("input stalled with a bubble in the pipeline");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4) |=> out_v_q)
    else $error("stage 3 item lost on advance");

endmodule

`default_nettype wire
